// File: rtl/bbn_pkg.sv
`default_nettype none

package bbn_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;

  // Reciprocal is floor(2^RECIP_EXP / size); products are shifted down by RECIP_SHIFT.
  localparam int RECIP_SHIFT = COORD_WIDTH + 1;
  localparam int RECIP_EXP   = RECIP_SHIFT + OUT_FRAC_BITS + 1;
  localparam int RECIP_WIDTH = RECIP_EXP + 1;

  // The reciprocal is split in two halves for the shared multiplier.
  localparam int RECIP_LO_W = (RECIP_WIDTH + 1) / 2;
  localparam int RECIP_HI_W = RECIP_WIDTH - RECIP_LO_W;
  localparam int PROD_W     = COORD_WIDTH + RECIP_LO_W;
  localparam int SUM_W      = COORD_WIDTH + RECIP_WIDTH;

  localparam int DIV_CNT_W = $clog2(RECIP_WIDTH);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RECIP_WIDTH - 1);

  localparam int AXES   = 3;
  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] AXIS_FIRST = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_LAST  = AXIS_W'(AXES - 1);

  localparam logic REQ_MEASURE   = 1'b0;
  localparam logic REQ_TRANSFORM = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_WIDTH-1:0]   norm_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
  localparam norm_t  ONE_VAL   = norm_t'(1) <<< OUT_FRAC_BITS;
  localparam norm_t  NEG_ONE   = -ONE_VAL;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_DIVIDE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACCUM,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic              measure;
    logic              transform;
    logic              size_load;
    logic              div_step;
    logic              div_last;
    logic              mul_lo;
    logic              mul_hi;
    logic              accum;
    logic [AXIS_W-1:0] axis;
    logic              out_load;
  } bbn_cmd_t;

  typedef struct packed {
    logic degenerate;
  } bbn_status_t;

endpackage

`default_nettype wire

// File: rtl/bbn_datapath.sv
`default_nettype none

module bbn_datapath (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  bbn_pkg::bbn_cmd_t cmd_i,
  output bbn_pkg::bbn_status_t    status_o,
  input  wire  bbn_pkg::coord_t   coord_x_i,
  input  wire  bbn_pkg::coord_t   coord_y_i,
  input  wire  bbn_pkg::coord_t   coord_z_i,
  output bbn_pkg::norm_t          norm_x_o,
  output bbn_pkg::norm_t          norm_y_o,
  output bbn_pkg::norm_t          norm_z_o,
  output logic                    degenerate_o
);

  localparam int CW  = bbn_pkg::COORD_WIDTH;
  localparam int RW  = bbn_pkg::RECIP_WIDTH;
  localparam int LW  = bbn_pkg::RECIP_LO_W;
  localparam int PW  = bbn_pkg::PROD_W;
  localparam int SW  = bbn_pkg::SUM_W;
  localparam int QLO = bbn_pkg::RECIP_SHIFT;
  localparam int QHI = bbn_pkg::RECIP_SHIFT + bbn_pkg::OUT_FRAC_BITS;

  bbn_pkg::coord_t coord [bbn_pkg::AXES];

  bbn_pkg::coord_t low_q  [bbn_pkg::AXES];
  bbn_pkg::coord_t low_d  [bbn_pkg::AXES];
  bbn_pkg::coord_t high_q [bbn_pkg::AXES];
  bbn_pkg::coord_t high_d [bbn_pkg::AXES];
  logic [RW-1:0]   recip_q;
  logic            seen_q;
  logic            pass_q;

  logic [CW-1:0]   diff_q [bbn_pkg::AXES];
  logic            dpos_q [bbn_pkg::AXES];
  logic [CW:0]     diff_full [bbn_pkg::AXES];
  logic [CW-1:0]   ext [bbn_pkg::AXES];
  logic [CW-1:0]   size;

  logic [CW-1:0]   divisor_q;
  logic [CW-1:0]   rem_q;
  logic [RW-1:0]   quot_q;
  logic [CW:0]     rem_sh;
  logic            div_ge;
  logic [CW:0]     rem_sub;
  logic [RW-1:0]   quot_nx;

  logic [LW-1:0]   mul_op;
  logic [CW-1:0]   mul_d;
  logic [PW-1:0]   prod;
  logic [PW-1:0]   prod_q;
  logic [PW-1:0]   lo_q;
  logic [SW-1:0]   sum;
  logic            over;
  bbn_pkg::norm_t  scaled;
  bbn_pkg::norm_t  axis_res;
  bbn_pkg::norm_t  res_q [bbn_pkg::AXES];

  bbn_pkg::norm_t  norm_x_q, norm_y_q, norm_z_q;
  logic            deg_q;
  logic            degenerate;

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  assign degenerate          = !seen_q || (recip_q == '0);
  assign status_o.degenerate = degenerate;

  // A measure item after a transform pass starts from an empty box.
  always_comb begin
    for (int a = 0; a < bbn_pkg::AXES; a++) begin
      bbn_pkg::coord_t base_low;
      bbn_pkg::coord_t base_high;
      base_low     = pass_q ? bbn_pkg::COORD_MAX : low_q[a];
      base_high    = pass_q ? bbn_pkg::COORD_MIN : high_q[a];
      low_d[a]     = (coord[a] < base_low)  ? coord[a] : base_low;
      high_d[a]    = (coord[a] > base_high) ? coord[a] : base_high;
      ext[a]       = high_q[a] - low_q[a];
      diff_full[a] = {coord[a][CW-1], coord[a]} - {low_q[a][CW-1], low_q[a]};
    end
  end

  always_comb begin
    size = ext[0];
    if (ext[1] > size) size = ext[1];
    if (ext[2] > size) size = ext[2];
  end

  // Restoring divider, one quotient bit a cycle; the dividend sits in quot_q.
  assign rem_sh  = {rem_q, quot_q[RW-1]};
  assign div_ge  = rem_sh >= {1'b0, divisor_q};
  assign rem_sub = div_ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
  assign quot_nx = {quot_q[RW-2:0], div_ge};

  assign mul_op = cmd_i.mul_hi ? LW'(recip_q[RW-1:LW]) : recip_q[LW-1:0];
  assign mul_d  = diff_q[cmd_i.axis];
  assign prod   = PW'(mul_d) * PW'(mul_op);

  assign sum    = (SW'(prod_q) << LW) + SW'(lo_q);
  assign over   = sum[SW-1:QHI+1] != '0;
  assign scaled = bbn_pkg::norm_t'({1'b0, sum[QHI:QLO]}) - bbn_pkg::ONE_VAL;

  always_comb begin
    if (!dpos_q[cmd_i.axis]) begin
      axis_res = bbn_pkg::NEG_ONE;
    end else if (over) begin
      axis_res = bbn_pkg::ONE_VAL;
    end else begin
      axis_res = scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < bbn_pkg::AXES; a++) begin
        low_q[a]  <= bbn_pkg::COORD_MAX;
        high_q[a] <= bbn_pkg::COORD_MIN;
      end
      recip_q <= '0;
      seen_q  <= 1'b0;
      pass_q  <= 1'b0;
    end else begin
      if (cmd_i.measure) begin
        for (int a = 0; a < bbn_pkg::AXES; a++) begin
          low_q[a]  <= low_d[a];
          high_q[a] <= high_d[a];
        end
        if (pass_q) recip_q <= '0;
        seen_q <= 1'b1;
        pass_q <= 1'b0;
      end
      if (cmd_i.transform) pass_q <= 1'b1;
      if (cmd_i.div_last) recip_q <= (divisor_q == '0) ? '0 : quot_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.transform) begin
      for (int a = 0; a < bbn_pkg::AXES; a++) begin
        diff_q[a] <= diff_full[a][CW-1:0];
        dpos_q[a] <= !diff_full[a][CW] && (diff_full[a] != '0);
      end
    end
    if (cmd_i.size_load) begin
      divisor_q <= size;
      rem_q     <= '0;
      quot_q    <= {1'b1, {(RW - 1){1'b0}}};
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_sub[CW-1:0];
      quot_q <= quot_nx;
    end
    if (cmd_i.mul_lo) prod_q <= prod;
    if (cmd_i.mul_hi) begin
      lo_q   <= prod_q;
      prod_q <= prod;
    end
    if (cmd_i.accum) res_q[cmd_i.axis] <= axis_res;
    if (cmd_i.out_load) begin
      norm_x_q <= degenerate ? bbn_pkg::NEG_ONE : res_q[0];
      norm_y_q <= degenerate ? bbn_pkg::NEG_ONE : res_q[1];
      norm_z_q <= degenerate ? bbn_pkg::NEG_ONE : res_q[2];
      deg_q    <= degenerate;
    end
  end

  assign norm_x_o     = norm_x_q;
  assign norm_y_o     = norm_y_q;
  assign norm_z_o     = norm_z_q;
  assign degenerate_o = deg_q;

endmodule

`default_nettype wire

// File: rtl/bbn_ctrl.sv
`default_nettype none

module bbn_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        req_type_i,
  input  wire                        last_vertex_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  input  wire  bbn_pkg::bbn_status_t status_i,
  output bbn_pkg::bbn_cmd_t          cmd_o
);

  bbn_pkg::ctrl_state_e              state_q, state_d;
  logic [bbn_pkg::AXIS_W-1:0]        axis_q, axis_d;
  logic [bbn_pkg::DIV_CNT_W-1:0]     div_cnt_q, div_cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic                              in_accept;
  logic                              slot_free;

  assign in_accept = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    div_cnt_d = div_cnt_q;
    unique case (state_q)
      bbn_pkg::ST_IDLE: begin
        if (in_accept) begin
          axis_d = bbn_pkg::AXIS_FIRST;
          if (req_type_i == bbn_pkg::REQ_MEASURE) begin
            if (last_vertex_i) state_d = bbn_pkg::ST_SIZE;
          end else if (status_i.degenerate) begin
            state_d = bbn_pkg::ST_EMIT;
          end else begin
            state_d = bbn_pkg::ST_MUL_LO;
          end
        end
      end
      bbn_pkg::ST_SIZE: begin
        div_cnt_d = '0;
        state_d   = bbn_pkg::ST_DIVIDE;
      end
      bbn_pkg::ST_DIVIDE: begin
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == bbn_pkg::DIV_LAST) state_d = bbn_pkg::ST_IDLE;
      end
      bbn_pkg::ST_MUL_LO: state_d = bbn_pkg::ST_MUL_HI;
      bbn_pkg::ST_MUL_HI: state_d = bbn_pkg::ST_ACCUM;
      bbn_pkg::ST_ACCUM: begin
        if (axis_q == bbn_pkg::AXIS_LAST) begin
          state_d = bbn_pkg::ST_EMIT;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = bbn_pkg::ST_MUL_LO;
        end
      end
      bbn_pkg::ST_EMIT: begin
        if (slot_free) state_d = bbn_pkg::ST_IDLE;
      end
      default: state_d = bbn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      bbn_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.measure   = in_valid_i && (req_type_i == bbn_pkg::REQ_MEASURE);
        cmd_o.transform = in_valid_i && (req_type_i == bbn_pkg::REQ_TRANSFORM);
      end
      bbn_pkg::ST_SIZE:   cmd_o.size_load = 1'b1;
      bbn_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = div_cnt_q == bbn_pkg::DIV_LAST;
      end
      bbn_pkg::ST_MUL_LO: cmd_o.mul_lo   = 1'b1;
      bbn_pkg::ST_MUL_HI: cmd_o.mul_hi   = 1'b1;
      bbn_pkg::ST_ACCUM:  cmd_o.accum    = 1'b1;
      bbn_pkg::ST_EMIT:   cmd_o.out_load = slot_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbn_pkg::ST_IDLE;
      axis_q      <= bbn_pkg::AXIS_FIRST;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.size_load, cmd_o.div_step, cmd_o.mul_lo, cmd_o.mul_hi, cmd_o.accum,
              cmd_o.out_load, cmd_o.measure, cmd_o.transform}))
    else $error("more than one datapath step commanded");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  a_divide_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbn_pkg::ST_DIVIDE && div_cnt_q == bbn_pkg::DIV_LAST)
      |=> state_q == bbn_pkg::ST_IDLE)
    else $error("divider did not finish after its last step");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbn_pkg::ST_MUL_LO || state_q == bbn_pkg::ST_MUL_HI ||
     state_q == bbn_pkg::ST_ACCUM) |-> axis_q <= bbn_pkg::AXIS_LAST)
    else $error("axis counter out of range");

endmodule

`default_nettype wire

// File: rtl/bounding_box_normalizer.sv
`default_nettype none
// Measure request: one per cycle while idle; the last one of a box then runs a
// one-bit-per-cycle reciprocal divider, and the next request waits until it is done.
// Transform request: three axes share one 24x21 multiplier, each axis in low multiply,
// high multiply and accumulate steps, then the result is emitted (directly if degenerate);
// the next request is taken in the cycle the result appears unless an earlier result waits unread.
// Reset (asynchronous, active low) empties the box and clears reciprocal and pass flags.

module bounding_box_normalizer (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire                   req_type_i,
  input  wire  bbn_pkg::coord_t coord_x_i,
  input  wire  bbn_pkg::coord_t coord_y_i,
  input  wire  bbn_pkg::coord_t coord_z_i,
  input  wire                   last_vertex_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output bbn_pkg::norm_t        norm_x_o,
  output bbn_pkg::norm_t        norm_y_o,
  output bbn_pkg::norm_t        norm_z_o,
  output logic                  degenerate_o
);

  bbn_pkg::bbn_cmd_t    cmd;
  bbn_pkg::bbn_status_t status;

  bbn_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  bbn_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .norm_x_o     (norm_x_o),
    .norm_y_o     (norm_y_o),
    .norm_z_o     (norm_z_o),
    .degenerate_o (degenerate_o)
  );

endmodule

`default_nettype wire
